// ===== rtl/u16u8_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, status codes and UTF-8 byte helpers for the UTF-16 to UTF-8
// encoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_SRC_EXHAUSTED = 2'd1,
    ST_TGT_EXHAUSTED = 2'd2,
    ST_SRC_ILLEGAL   = 2'd3
  } status_t;

  typedef struct packed {
    logic        strict;
    logic [15:0] cap;
  } cfg_t;

  // One queued job: up to two characters, then an optional status.
  typedef struct packed {
    logic [20:0] c0;
    logic [2:0]  len0;
    logic [15:0] c1;
    logic [2:0]  len1;
    logic        has_st;
    status_t     st_code;
  } desc_t;

  localparam int unsigned QDEPTH = 2;

  function automatic logic [2:0] len16(input logic [15:0] u);
    logic [2:0] l;
    if (u < 16'h0080) begin
      l = 3'd1;
    end else if (u < 16'h0800) begin
      l = 3'd2;
    end else begin
      l = 3'd3;
    end
    return l;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] ch, input logic [2:0] len,
                                           input logic [1:0] idx);
    logic [7:0] b;
    logic [2:0] grp;
    grp = 3'(len - 3'd1 - {1'b0, idx});
    if (idx == 2'd0) begin
      case (len)
        3'd1:    b = ch[7:0];
        3'd2:    b = 8'hC0 | {3'b000, ch[10:6]};
        3'd3:    b = 8'hE0 | {4'b0000, ch[15:12]};
        default: b = 8'hF0 | {5'b00000, ch[20:18]};
      endcase
    end else begin
      case (grp[1:0])
        2'd0:    b = {2'b10, ch[5:0]};
        2'd1:    b = {2'b10, ch[11:6]};
        default: b = {2'b10, ch[17:12]};
      endcase
    end
    return b;
  endfunction

endpackage

// ===== rtl/u16u8_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts UTF-16 code units, tracks surrogates, byte count and error state,
// and pushes one encoding job per unit that produces output.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic              clk,
  input  logic              rst_n,
  input  u16u8_pkg::cfg_t   cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       in_code_unit,
  input  logic              q_ready,
  output logic              push,
  output u16u8_pkg::desc_t  desc
);

  logic        held_r, held_nxt;
  logic [15:0] hu_r, hu_nxt;
  logic [15:0] bw_r, bw_nxt;
  logic        disc_r, disc_nxt;

  logic        is_zero, is_high, is_low, ok, fail;
  u16u8_pkg::status_t fcode;
  logic [2:0]  ulen;
  logic [16:0] cap17, pair_need, hold_need, base, unit_need;
  logic [20:0] pair;

  assign in_ready  = q_ready;
  assign is_zero   = (in_code_unit == 16'h0000);
  assign is_high   = (in_code_unit[15:10] == 6'b110110);
  assign is_low    = (in_code_unit[15:10] == 6'b110111);
  assign ulen      = u16u8_pkg::len16(in_code_unit);
  assign cap17     = {1'b0, cfg.cap};
  assign pair_need = {1'b0, bw_r} + 17'd4;
  assign hold_need = {1'b0, bw_r} + 17'd3;
  assign pair      = {1'b0, hu_r[9:0], in_code_unit[9:0]} + 21'h10000;

  always_comb begin
    push      = 1'b0;
    desc      = '0;
    held_nxt  = held_r;
    hu_nxt    = hu_r;
    bw_nxt    = bw_r;
    disc_nxt  = disc_r;
    ok        = 1'b1;
    fail      = 1'b0;
    fcode     = u16u8_pkg::ST_OK;
    base      = {1'b0, bw_r};
    unit_need = '0;
    if (in_valid && in_ready) begin
      if (disc_r) begin
        if (is_zero) begin
          disc_nxt = 1'b0;
          held_nxt = 1'b0;
          hu_nxt   = '0;
          bw_nxt   = '0;
        end
      end else if (is_zero) begin
        push         = 1'b1;
        desc.has_st  = 1'b1;
        desc.st_code = held_r ? u16u8_pkg::ST_SRC_EXHAUSTED : u16u8_pkg::ST_OK;
        held_nxt     = 1'b0;
        hu_nxt       = '0;
        bw_nxt       = '0;
      end else if (held_r && is_low) begin
        held_nxt = 1'b0;
        hu_nxt   = '0;
        if (pair_need > cap17) begin
          fail  = 1'b1;
          fcode = u16u8_pkg::ST_TGT_EXHAUSTED;
        end else begin
          push      = 1'b1;
          desc.c0   = pair;
          desc.len0 = 3'd4;
          bw_nxt    = pair_need[15:0];
        end
      end else if (held_r && cfg.strict) begin
        fail  = 1'b1;
        fcode = u16u8_pkg::ST_SRC_ILLEGAL;
      end else begin
        if (held_r) begin
          held_nxt = 1'b0;
          hu_nxt   = '0;
          if (hold_need > cap17) begin
            fail  = 1'b1;
            fcode = u16u8_pkg::ST_TGT_EXHAUSTED;
            ok    = 1'b0;
          end else begin
            push      = 1'b1;
            desc.c0   = {5'b00000, hu_r};
            desc.len0 = 3'd3;
            base      = hold_need;
          end
        end
        if (ok) begin
          if (is_high) begin
            held_nxt = 1'b1;
            hu_nxt   = in_code_unit;
            bw_nxt   = base[15:0];
          end else if (is_low && cfg.strict) begin
            fail  = 1'b1;
            fcode = u16u8_pkg::ST_SRC_ILLEGAL;
          end else begin
            unit_need = base + {14'b0, ulen};
            if (unit_need > cap17) begin
              fail  = 1'b1;
              fcode = u16u8_pkg::ST_TGT_EXHAUSTED;
            end else begin
              push      = 1'b1;
              desc.c1   = in_code_unit;
              desc.len1 = ulen;
              bw_nxt    = unit_need[15:0];
            end
          end
        end
      end
      if (fail) begin
        push         = 1'b1;
        desc.has_st  = 1'b1;
        desc.st_code = fcode;
        disc_nxt     = 1'b1;
        held_nxt     = 1'b0;
        hu_nxt       = '0;
        bw_nxt       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      hu_r   <= '0;
      bw_r   <= '0;
      disc_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
      hu_r   <= hu_nxt;
      bw_r   <= bw_nxt;
      disc_r <= disc_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_held_is_high: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> (hu_r[15:10] == 6'b110110))
    else $error("held unit is not a high surrogate");
  a_held_not_disc: assert property (@(posedge clk) disable iff (!rst_n)
    !(held_r && disc_r))
    else $error("surrogate held while discarding");
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (in_valid && in_ready))
    else $error("job pushed without an input transfer");
`endif

endmodule

// ===== rtl/u16u8_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_queue
// Two-entry job queue between the classifying front end and the byte
// sequencer.
// ----------------------------------------------------------------------------
module u16u8_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  u16u8_pkg::desc_t  wr_data,
  output logic              wr_ready,
  input  logic              pop,
  output logic              rd_valid,
  output u16u8_pkg::desc_t  rd_data
);

  u16u8_pkg::desc_t mem [u16u8_pkg::QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign wr_ready = (cnt_r != 2'(u16u8_pkg::QDEPTH));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (push && wr_ready);
    rd_ptr_nxt = rd_ptr_r + (pop && rd_valid);
    cnt_nxt    = cnt_r + {1'b0, (push && wr_ready)} - {1'b0, (pop && rd_valid)};
  end

  always_ff @(posedge clk) begin
    if (push && wr_ready) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/u16u8_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_back
// Walks each queued job and sends its UTF-8 bytes and status one transfer
// per cycle while out_ready allows, through a registered output stage.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  u16u8_pkg::desc_t  q_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_is_status,
  output logic [1:0]        out_status_code,
  output logic              out_last_of_run
);

  logic       ov_r, ov_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       st_r, st_nxt;
  logic [1:0] code_r, code_nxt;
  logic       last_r, last_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  logic       advance, is_last;
  logic [3:0] cnt4, end0, end1, total;
  logic [3:0] off1;

  assign advance = !ov_r || out_ready;
  assign cnt4    = {1'b0, cnt_r};
  assign end0    = {1'b0, q_data.len0};
  assign end1    = end0 + {1'b0, q_data.len1};
  assign total   = end1 + {3'b000, q_data.has_st};
  assign is_last = (cnt4 == total - 4'd1);
  assign off1    = cnt4 - end0;
  assign pop     = advance && q_valid && is_last;

  always_comb begin
    ov_nxt   = ov_r;
    byte_nxt = byte_r;
    st_nxt   = st_r;
    code_nxt = code_r;
    last_nxt = last_r;
    cnt_nxt  = cnt_r;
    if (advance) begin
      ov_nxt = q_valid;
      if (q_valid) begin
        last_nxt = is_last;
        cnt_nxt  = is_last ? 3'd0 : cnt_r + 3'd1;
        st_nxt   = 1'b0;
        code_nxt = u16u8_pkg::ST_OK;
        if (cnt4 < end0) begin
          byte_nxt = u16u8_pkg::utf8_byte(q_data.c0, q_data.len0, cnt_r[1:0]);
        end else if (cnt4 < end1) begin
          byte_nxt = u16u8_pkg::utf8_byte({5'b00000, q_data.c1}, q_data.len1, off1[1:0]);
        end else begin
          byte_nxt = 8'h00;
          st_nxt   = 1'b1;
          code_nxt = q_data.st_code;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      cnt_r  <= 3'd0;
      byte_r <= '0;
      st_r   <= 1'b0;
      code_r <= '0;
      last_r <= 1'b0;
    end else begin
      ov_r   <= ov_nxt;
      cnt_r  <= cnt_nxt;
      byte_r <= byte_nxt;
      st_r   <= st_nxt;
      code_r <= code_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_byte        = byte_r;
  assign out_is_status   = st_r;
  assign out_status_code = code_r;
  assign out_last_of_run = last_r;

`ifndef NO_ASSERTIONS
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && st_r) |-> last_r)
    else $error("status transfer is not the last of its run");
  a_status_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && st_r) |-> (byte_r == 8'h00))
    else $error("status transfer carries a nonzero byte");
  a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (cnt_r == 3'd0) && ov_r && last_r)
    else $error("job retired without its last transfer");
`endif

endmodule

// ===== rtl/utf16_to_utf8_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// UTF-16 to UTF-8 stream encoder with surrogate pairing, capacity check and
// error status.
// ----------------------------------------------------------------------------
// Each code unit is accepted by the front end, which pairs
// surrogates, checks the byte budget and queues a job; a new unit can be taken
// every cycle while the two-entry job queue has room. The byte sequencer sends
// one transfer per cycle while out_ready allows, and a unit costs the output
// transfers it causes: none for a held high surrogate or a dropped unit, one
// to four bytes for a character, and up to six bytes, or three bytes and a
// status, when a lenient lone surrogate precedes another character. Sustained
// throughput is thus set by the one-byte output channel. A terminator gives
// one status transfer unless the block is dropping units after an error.
module utf16_to_utf8_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_code_unit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_is_status,
  output logic [1:0]  out_status_code,
  output logic        out_last_of_run
);

  logic        strict_r, strict_nxt;
  logic [15:0] cap_r, cap_nxt;
  logic        wr_en;

  u16u8_pkg::cfg_t  cfg;
  u16u8_pkg::desc_t push_desc, head_desc;
  logic             push, q_ready, q_valid, pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? {16'h0000, cap_r} : {31'h00000000, strict_r};

  always_comb begin
    strict_nxt = strict_r;
    cap_nxt    = cap_r;
    if (wr_en) begin
      if (paddr[2]) begin
        cap_nxt = pwdata[15:0];
      end else begin
        strict_nxt = pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r <= 1'b1;
      cap_r    <= 16'hFFFF;
    end else begin
      strict_r <= strict_nxt;
      cap_r    <= cap_nxt;
    end
  end

  assign cfg.strict = strict_r;
  assign cfg.cap    = cap_r;

  u16u8_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_code_unit (in_code_unit),
    .q_ready      (q_ready),
    .push         (push),
    .desc         (push_desc)
  );

  u16u8_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_data  (push_desc),
    .wr_ready (q_ready),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_data  (head_desc)
  );

  u16u8_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (head_desc),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_is_status   (out_is_status),
    .out_status_code (out_status_code),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== tb/utf8_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_checker
// Watches the configuration port and both streams of the UTF-16 to UTF-8
// encoder, predicts the UTF-8 bytes and status results of every accepted code
// unit, and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_checker
  import u16u8_pkg::*;
#(
  parameter logic [2:0] STRICT_ADDR = 3'd0,
  parameter logic [2:0] CAP_ADDR    = 3'd4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_code_unit,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        out_is_status,
  input  logic [1:0]  out_status_code,
  input  logic        out_last_of_run,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  typedef struct {
    logic [7:0] data;
    logic       is_status;
    status_t    code;
    logic       last;
  } utf8_result_t;

  utf8_result_t step_results[$];
  utf8_result_t expected_bytes[$];

  logic        strict;
  int          capacity;
  logic [15:0] held_hi;
  logic        held_v;
  int          written;
  logic        dropping;

  function automatic void add_result(logic [7:0] d, logic st, status_t c);
    utf8_result_t r;
    r.data = d;
    r.is_status = st;
    r.code = c;
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void clear_string();
    held_hi = 16'h0000;
    held_v = 1'b0;
    written = 0;
  endfunction

  function automatic void abort_string(status_t c);
    add_result(8'h00, 1'b1, c);
    clear_string();
    dropping = 1'b1;
  endfunction

  function automatic bit encode_char(int ch);
    int len;
    int i;
    logic [7:0] lead;
    if (ch < 'h80) len = 1;
    else if (ch < 'h800) len = 2;
    else if (ch < 'h10000) len = 3;
    else len = 4;
    if (written + len > capacity) begin
      abort_string(ST_TGT_EXHAUSTED);
      return 1'b0;
    end
    case (len)
      1: lead = 8'(ch);
      2: lead = 8'hC0 | 8'(ch >> 6);
      3: lead = 8'hE0 | 8'(ch >> 12);
      default: lead = 8'hF0 | 8'(ch >> 18);
    endcase
    add_result(lead, 1'b0, ST_OK);
    for (i = len - 1; i > 0; i--) begin
      add_result({2'b10, 6'(ch >> (6 * (i - 1)))}, 1'b0, ST_OK);
    end
    written += len;
    return 1'b1;
  endfunction

  function automatic void predict_unit(logic [15:0] u);
    bit hi;
    bit lo;
    bit done;
    int ch;
    step_results.delete();
    hi = (u >= 16'hD800) && (u <= 16'hDBFF);
    lo = (u >= 16'hDC00) && (u <= 16'hDFFF);
    done = 1'b0;
    if (dropping) begin
      if (u == 16'h0000) begin
        dropping = 1'b0;
        clear_string();
      end
      return;
    end
    if (u == 16'h0000) begin
      add_result(8'h00, 1'b1, held_v ? ST_SRC_EXHAUSTED : ST_OK);
      clear_string();
    end else begin
      if (held_v) begin
        if (lo) begin
          ch = ((int'(held_hi) - 'hD800) << 10) + (int'(u) - 'hDC00) + 'h10000;
          held_v = 1'b0;
          held_hi = 16'h0000;
          void'(encode_char(ch));
          done = 1'b1;
        end else if (strict) begin
          abort_string(ST_SRC_ILLEGAL);
          done = 1'b1;
        end else begin
          held_v = 1'b0;
          if (!encode_char(int'(held_hi))) done = 1'b1;
          else held_hi = 16'h0000;
        end
      end
      if (!done) begin
        if (hi) begin
          held_hi = u;
          held_v = 1'b1;
        end else if (lo && strict) begin
          abort_string(ST_SRC_ILLEGAL);
        end else begin
          void'(encode_char(int'(u)));
        end
      end
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
  end

  always @(posedge clk) begin : monitor
    utf8_result_t want;
    if (!rst_n) begin
      strict = 1'b1;
      capacity = 65535;
      clear_string();
      dropping = 1'b0;
      expected_bytes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == STRICT_ADDR) strict = pwdata[0];
        else if (paddr == CAP_ADDR) capacity = int'(pwdata[15:0]);
      end
      if (in_valid && in_ready) begin
        predict_unit(in_code_unit);
        foreach (step_results[k]) expected_bytes.push_back(step_results[k]);
      end
      if (out_valid && out_ready) begin
        checked++;
        if (expected_bytes.size() == 0) begin
          $error("unexpected result transfer: byte %0h status %0b code %0d",
                 out_byte, out_is_status, out_status_code);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte expected %0h, got %0h", want.data, out_byte);
            fail_count++;
          end
          if (out_is_status !== want.is_status) begin
            $error("out_is_status expected %0b, got %0b", want.is_status, out_is_status);
            fail_count++;
          end
          if (out_status_code !== want.code) begin
            $error("out_status_code expected %0d, got %0d", want.code, out_status_code);
            fail_count++;
          end
          if (out_last_of_run !== want.last) begin
            $error("out_last_of_run expected %0b, got %0b", want.last, out_last_of_run);
            fail_count++;
          end
        end
      end
    end
    pending = expected_bytes.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench top for the UTF-16 to UTF-8 encoder. Drives directed and random
// code unit strings under several register settings with random stalls on
// both streams, and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb;
  import u16u8_pkg::*;

  localparam logic [2:0] REG_STRICT = 3'd0;
  localparam logic [2:0] REG_CAP    = 3'd4;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SETTLE       = 16;
  localparam int HOLD_CYCLES  = 150;
  localparam int PHASE_UNITS  = 14;
  localparam int NUM_PHASES   = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_code_unit = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_is_status;
  logic [1:0]  out_status_code;
  logic        out_last_of_run;

  int fail_count;
  int pending;
  int checked;
  int units_sent = 0;
  int quiet = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit calm = 1'b0;

  logic        phase_strict [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  logic [15:0] phase_cap [NUM_PHASES] = '{16'd65535, 16'd0, 16'd12, 16'd65535, 16'd5,
                                          16'd300};

  utf16_to_utf8_encoder u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_code_unit    (in_code_unit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_is_status   (out_is_status),
    .out_status_code (out_status_code),
    .out_last_of_run (out_last_of_run)
  );

  utf8_checker #(
    .STRICT_ADDR (REG_STRICT),
    .CAP_ADDR    (REG_CAP)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_code_unit    (in_code_unit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_is_status   (out_is_status),
    .out_status_code (out_status_code),
    .out_last_of_run (out_last_of_run),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked         (checked)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 33);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $error("no transfer for %0d cycles", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_unit(logic [15:0] u);
    if (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_code_unit <= u;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    units_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_bmp();
    logic [15:0] u;
    case ($urandom_range(0, 3))
      0: u = 16'($urandom_range(1, 'h7F));
      1: u = 16'($urandom_range('h80, 'h7FF));
      2: u = 16'($urandom_range('h800, 'hD7FF));
      default: u = 16'($urandom_range('hE000, 'hFFFF));
    endcase
    return u;
  endfunction

  task automatic random_string();
    int nchars;
    int kind;
    int k;
    nchars = $urandom_range(0, 6);
    for (k = 0; k < nchars; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        send_unit(rand_bmp());
      end else if (kind < 85) begin
        send_unit(16'($urandom_range('hD800, 'hDBFF)));
        send_unit(16'($urandom_range('hDC00, 'hDFFF)));
      end else if (kind < 90) begin
        send_unit(16'($urandom_range('hD800, 'hDBFF)));
      end else if (kind < 95) begin
        send_unit(16'($urandom_range('hDC00, 'hDFFF)));
      end else begin
        send_unit(16'($urandom_range(0, 'hFFFF)));
      end
    end
    if ($urandom_range(0, 9) != 0) send_unit(16'h0000);
  endtask

  initial begin
    int p;
    int start;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_unit(16'h0041);
    send_unit(16'h007F);
    send_unit(16'h0080);
    send_unit(16'h07FF);
    send_unit(16'hFFFF);
    send_unit(16'hD800);
    send_unit(16'hDC00);
    send_unit(16'hDBFF);
    send_unit(16'hDFFF);
    send_unit(16'h0000);
    send_unit(16'hDC00);
    send_unit(16'h0041);
    send_unit(16'h0000);
    send_unit(16'hD800);
    send_unit(16'h0041);
    send_unit(16'h0000);
    send_unit(16'hD800);
    send_unit(16'h0000);
    send_unit(16'hD800);
    send_unit(16'hD800);
    send_unit(16'h0000);
    drain();

    write_reg(REG_STRICT, 32'd0);
    write_reg(REG_CAP, 32'd5);
    send_unit(16'hDC00);
    send_unit(16'hD800);
    send_unit(16'h0041);
    send_unit(16'h0000);
    send_unit(16'hD800);
    send_unit(16'hD801);
    send_unit(16'h0000);
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_STRICT, {31'd0, phase_strict[p]});
      write_reg(REG_CAP, {16'd0, phase_cap[p]});
      if (p == 3) begin
        calm = 1'b1;
        hold_req = 1'b1;
      end
      start = units_sent;
      while (units_sent - start < PHASE_UNITS) begin
        random_string();
        if (p == 4 && units_sent - start >= PHASE_UNITS / 2 && pending != 0) drain();
      end
      send_unit(16'h0000);
      drain();
      calm = 1'b0;
    end

    $display("Run covered %0d code units and %0d result transfers over %0d register settings,",
             units_sent, checked, NUM_PHASES + 2);
    $display("both surrogate modes, capacities from 0 to 65535, and a long output stall.");
    if (pending != 0) begin
      $error("%0d expected results never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
